>>> rtl/core/dq_pkg.sv
// dq_pkg: operation and status codes, field widths and the cell control bundle
// for the double-ended queue. Depends on nothing; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

	localparam int OP_W     = 3;
	localparam int FIELD_W  = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_QUERY      = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic shift_r; // push front: every element moves one cell back
		logic shift_l; // pop front: every element moves one cell forward
		logic append;  // the cell flagged wr_here takes the new value
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/dq_ifs.sv
// Request and response channel interfaces of the double-ended queue.
// Depends on dq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dq_req_if;
	import dq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic signed [FIELD_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface dq_rsp_if;
	import dq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] front_value;
	logic signed [FIELD_W-1:0] back_value;
	logic                      is_empty;
	logic [COUNT_W-1:0]        count;
	logic [STATUS_W-1:0]       status;

	modport source (output valid, output front_value, output back_value, output is_empty,
		output count, output status, input ready);
	modport sink (input valid, input front_value, input back_value, input is_empty,
		input count, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/double_ended_queue.sv
// double_ended_queue: bounded deque held in a row of DEPTH shifting cells.
// The response is registered and is valid in the cycle after the request is taken.
// Throughput: one request per cycle; ready drops only while a response waits.
// Reset clears the element count and the response valid; cell contents are not reset.
// Depends on dq_pkg, dq_ifs (dq_req_if, dq_rsp_if) and dq_cell.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue import dq_pkg::*; #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	dq_req_if.sink   req,
	dq_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]                count_q;
	logic [CW-1:0]                count_nx;
	logic                         accept;
	logic                         full;
	logic                         empty;
	status_t                      status_nx;
	cell_ctrl_t                   ctrl;
	logic signed [DATA_WIDTH-1:0] push_val;

	logic [DATA_WIDTH-1:0] cell_q   [DEPTH];
	logic [DATA_WIDTH-1:0] cell_nx  [DEPTH];
	logic [DATA_WIDTH-1:0] back_tap [DEPTH];
	logic [DEPTH-1:0]      wr_here;
	logic [DEPTH-1:0]      last_here;
	logic [DATA_WIDTH-1:0] back_or;
	logic [DATA_WIDTH-1:0] front_nx;

	logic                         rsp_valid_q;
	logic signed [DATA_WIDTH-1:0] front_q;
	logic signed [DATA_WIDTH-1:0] back_q;
	logic                         is_empty_q;
	logic [COUNT_W-1:0]           count_out_q;
	status_t                      status_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign push_val  = DATA_WIDTH'(req.value);

	always_comb begin
		ctrl      = '0;
		count_nx  = count_q;
		status_nx = ST_OK;
		if (accept) begin
			unique case (op_t'(req.op))
				OP_PUSH_FRONT: begin
					if (full) begin
						status_nx = ST_FULL;
					end else begin
						ctrl.shift_r = 1'b1;
						count_nx     = CW'(count_q + 1'b1);
					end
				end
				OP_PUSH_BACK: begin
					if (full) begin
						status_nx = ST_FULL;
					end else begin
						ctrl.append = 1'b1;
						count_nx    = CW'(count_q + 1'b1);
					end
				end
				OP_POP_FRONT: begin
					if (empty) begin
						status_nx = ST_EMPTY;
					end else begin
						ctrl.shift_l = 1'b1;
						count_nx     = CW'(count_q - 1'b1);
					end
				end
				OP_POP_BACK: begin
					if (empty) begin
						status_nx = ST_EMPTY;
					end else begin
						count_nx = CW'(count_q - 1'b1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_in;
		logic [DATA_WIDTH-1:0] right_in;

		// push back lands just past the current last element
		assign wr_here[i]   = (count_q == CW'(i));
		assign last_here[i] = (count_nx == CW'(i + 1));

		// current neighbor contents feed the shifts
		if (i == 0) begin : g_head
			assign left_in = push_val;
		end else begin : g_body
			assign left_in = cell_q[i - 1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_in = '0;
		end else begin : g_inner
			assign right_in = cell_q[i + 1];
		end

		dq_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.wr_here  (wr_here[i]),
			.last_here(last_here[i]),
			.push_val (push_val),
			.left_in  (left_in),
			.right_in (right_in),
			.held     (cell_q[i]),
			.data_nx  (cell_nx[i]),
			.back_tap (back_tap[i])
		);
	end

	always_comb begin
		back_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_or = back_or | back_tap[i];
		end
	end

	assign front_nx = (count_nx == '0) ? '0 : cell_nx[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nx;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_q     <= front_nx;
			back_q      <= back_or;
			is_empty_q  <= (count_nx == '0);
			count_out_q <= COUNT_W'(count_nx);
			status_q    <= status_nx;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.front_value = FIELD_W'(front_q);
	assign rsp.back_value  = FIELD_W'(back_q);
	assign rsp.is_empty    = is_empty_q;
	assign rsp.count       = count_out_q;
	assign rsp.status      = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above depth");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> rsp.valid)
		else $error("accepted request produced no response");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.is_empty == (count_q == '0)))
		else $error("empty flag disagrees with count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_FULL) |-> count_q == CW'(DEPTH))
		else $error("push dropped while queue not full");

endmodule

`default_nettype wire

>>> rtl/core/dq_cell.sv
// dq_cell: one storage cell of the queue row. Holds one element and takes its
// neighbor's value on a shift. Depends on dq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dq_cell import dq_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire cell_ctrl_t            ctrl,
	input  wire logic                  wr_here,
	input  wire logic                  last_here,
	input  wire logic [DATA_WIDTH-1:0] push_val,
	input  wire logic [DATA_WIDTH-1:0] left_in,
	input  wire logic [DATA_WIDTH-1:0] right_in,
	output logic      [DATA_WIDTH-1:0] held,
	output logic      [DATA_WIDTH-1:0] data_nx,
	output logic      [DATA_WIDTH-1:0] back_tap
);

	logic [DATA_WIDTH-1:0] data_q;

	always_comb begin
		if (ctrl.shift_r) begin
			data_nx = left_in;
		end else if (ctrl.shift_l) begin
			data_nx = right_in;
		end else if (ctrl.append && wr_here) begin
			data_nx = push_val;
		end else begin
			data_nx = data_q;
		end
	end

	// only the cell that ends up last drives the back-value OR
	assign back_tap = last_here ? data_nx : '0;
	assign held     = data_q;

	always_ff @(posedge clk) begin
		data_q <= data_nx;
	end

endmodule

`default_nettype wire
